// File: src/vms_pkg.sv
package vms_pkg;

   // Component format
   localparam int COMP_W    = 16;
   localparam int FRAC_BITS = 8;
   localparam int SQ_W      = 2 * COMP_W;   // squared magnitude, fits three squares
   localparam int ROOT_W    = COMP_W;       // floor root of SQ_W bits
   localparam int REM_W     = ROOT_W + 2;   // root remainder
   localparam int NUM_W     = 2 * COMP_W;   // magnitude times length, and quotient
   localparam int LANES     = 3;

   // Pipeline depth: three front stages, root chain, decision, divide chain, output
   localparam int LATENCY   = 3 + ROOT_W + 1 + NUM_W + 1;

   localparam logic [COMP_W-1:0] ONE_FIX    = COMP_W'(1) << FRAC_BITS;
   localparam logic [COMP_W-1:0] LEN_RESET  = COMP_W'(256);

   // Register indexes
   localparam logic CSR_SCALE_MODE = 1'b0;
   localparam logic CSR_TARGET_LEN = 1'b1;

   typedef enum logic [1:0] {
      MODE_LIMIT = 2'd0,
      MODE_SET   = 2'd1,
      MODE_NORM  = 2'd2
   } mode_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] vec_x;
      logic signed [COMP_W-1:0] vec_y;
      logic signed [COMP_W-1:0] vec_z;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] out_x;
      logic signed [COMP_W-1:0] out_y;
      logic signed [COMP_W-1:0] out_z;
      logic                     was_scaled;
      logic                     saturated;
   } rsp_type;

   // One slot of the root chain
   typedef struct packed {
      logic                               valid;
      logic [1:0]                         mode;
      logic [COMP_W-1:0]                  len;
      logic                               nonzero;
      logic                               over;
      logic [LANES-1:0][COMP_W-1:0]       comp;
      logic [SQ_W-1:0]                    rad;
      logic [REM_W-1:0]                   rem;
      logic [ROOT_W-1:0]                  root;
   } sqrt_stage_type;

   // One slot of the divide chain, three lanes share the divisor
   typedef struct packed {
      logic                               valid;
      logic                               scale;
      logic [LANES-1:0][COMP_W-1:0]       comp;
      logic [LANES-1:0][NUM_W-1:0]        num;
      logic [LANES-1:0][ROOT_W-1:0]       rem;
      logic [ROOT_W-1:0]                  div;
   } div_stage_type;

endpackage

// File: src/vms_sqrt_cell.sv
module vms_sqrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  vms_pkg::sqrt_stage_type stage_in,
   output vms_pkg::sqrt_stage_type stage_out
);
   import vms_pkg::*;

   sqrt_stage_type   stage_ff;
   sqrt_stage_type   stage_in_c;
   logic [REM_W:0]   rem_sh;
   logic [REM_W:0]   trial;

   // One root bit: bring down two radicand bits, try subtracting 4*root+1
   always_comb begin
      stage_in_c = stage_in;
      rem_sh     = {stage_in.rem[REM_W-2:0], stage_in.rad[SQ_W-1 -: 2]};
      trial      = {1'b0, stage_in.root, 2'b01};
      stage_in_c.rad = {stage_in.rad[SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         stage_in_c.rem  = REM_W'(rem_sh - trial);
         stage_in_c.root = {stage_in.root[ROOT_W-2:0], 1'b1};
      end else begin
         stage_in_c.rem  = REM_W'(rem_sh);
         stage_in_c.root = {stage_in.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in_c;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

   assign stage_out = stage_ff;

endmodule

// File: src/vms_div_cell.sv
module vms_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  vms_pkg::div_stage_type stage_in,
   output vms_pkg::div_stage_type stage_out
);
   import vms_pkg::*;

   div_stage_type   stage_ff;
   div_stage_type   stage_in_c;
   logic [ROOT_W:0] rem_sh [LANES];

   // One quotient bit per lane: shift in a dividend bit, subtract if it fits
   always_comb begin
      stage_in_c = stage_in;
      for (int i = 0; i < LANES; i++) begin
         rem_sh[i] = {stage_in.rem[i], stage_in.num[i][NUM_W-1]};
         if (rem_sh[i] >= {1'b0, stage_in.div}) begin
            stage_in_c.rem[i] = ROOT_W'(rem_sh[i] - {1'b0, stage_in.div});
            stage_in_c.num[i] = {stage_in.num[i][NUM_W-2:0], 1'b1};
         end else begin
            stage_in_c.rem[i] = rem_sh[i][ROOT_W-1:0];
            stage_in_c.num[i] = {stage_in.num[i][NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in_c;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

   assign stage_out = stage_ff;

endmodule

// File: src/vector_magnitude_scaler.sv
// Throughput: one vector per cycle; busy stays low and results cannot be held off.
// Latency is set by the root chain (one root bit per cell, 16 cells) and the
// divide chain (one quotient bit per cell, 32 cells), plus front and end stages.
// Synchronous active-high reset empties the pipeline and sets scale_mode to
// limit and target_length to 1.0.
module vector_magnitude_scaler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  vms_pkg::req_type               req,
   output logic                           rsp_strobe,
   output vms_pkg::rsp_type               rsp,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_addr,
   input  logic [vms_pkg::COMP_W-1:0]     csr_wdata
);
   import vms_pkg::*;

   logic [1:0]                     scale_mode_ff;
   logic [COMP_W-1:0]              target_len_ff;

   logic                           s1_valid_ff;
   logic [LANES-1:0][COMP_W-1:0]   s1_comp_ff;
   logic [1:0]                     s1_mode_ff;
   logic [COMP_W-1:0]              s1_len_ff;

   logic                           s2_valid_ff;
   logic [LANES-1:0][COMP_W-1:0]   s2_comp_ff;
   logic [1:0]                     s2_mode_ff;
   logic [COMP_W-1:0]              s2_len_ff;
   logic [LANES-1:0][SQ_W-1:0]     s2_sq_ff;
   logic [SQ_W-1:0]                s2_lensq_ff;

   logic [LANES-1:0][COMP_W-1:0]   s1_mag_in;
   logic [SQ_W-1:0]                s3_sum_in;

   sqrt_stage_type                 sq_chain [ROOT_W+1];
   sqrt_stage_type                 s3_ff;
   div_stage_type                  dv_chain [NUM_W+1];
   div_stage_type                  dec_in;
   div_stage_type                  dec_ff;

   logic [COMP_W-1:0]              len_eff;
   logic                           scale_in;
   logic [COMP_W-1:0]              mag_d [LANES];
   rsp_type                        rsp_in;
   rsp_type                        rsp_ff;
   logic                           rsp_valid_ff;
   logic [LANES-1:0][COMP_W-1:0]   res_comp;
   logic [LANES-1:0]               res_sat;
   logic [NUM_W-1:0]               quot;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_mode_ff <= MODE_LIMIT;
         target_len_ff <= LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_addr)
            CSR_SCALE_MODE: scale_mode_ff <= csr_wdata[1:0];
            CSR_TARGET_LEN: target_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: capture the transaction
   always_ff @(posedge clock) begin
      s1_comp_ff <= {req.vec_z, req.vec_y, req.vec_x};
      s1_mode_ff <= scale_mode_ff;
      s1_len_ff  <= target_len_ff;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
   end

   // Stage 2: magnitudes squared and target length squared
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         s1_mag_in[i] = s1_comp_ff[i][COMP_W-1] ? (~s1_comp_ff[i] + 1'b1) : s1_comp_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         s2_sq_ff[i] <= s1_mag_in[i] * s1_mag_in[i];
      end
      s2_lensq_ff <= s1_len_ff * s1_len_ff;
      s2_comp_ff  <= s1_comp_ff;
      s2_mode_ff  <= s1_mode_ff;
      s2_len_ff   <= s1_len_ff;
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Stage 3: sum of squares, limit compare, root chain entry
   assign s3_sum_in = s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];

   always_ff @(posedge clock) begin
      s3_ff.mode    <= s2_mode_ff;
      s3_ff.len     <= s2_len_ff;
      s3_ff.nonzero <= s3_sum_in != '0;
      s3_ff.over    <= s3_sum_in > s2_lensq_ff;
      s3_ff.comp    <= s2_comp_ff;
      s3_ff.rad     <= s3_sum_in;
      s3_ff.rem     <= '0;
      s3_ff.root    <= '0;
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else begin
         s3_ff.valid <= s2_valid_ff;
      end
   end

   assign sq_chain[0] = s3_ff;

   // Root chain
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      vms_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (sq_chain[k]),
         .stage_out (sq_chain[k+1])
      );
   end

   // Decision stage: pick length and scale flag, form dividends
   always_comb begin
      len_eff  = sq_chain[ROOT_W].len;
      scale_in = 1'b0;
      case (mode_type'(sq_chain[ROOT_W].mode))
         MODE_LIMIT: scale_in = sq_chain[ROOT_W].over;
         MODE_SET:   scale_in = 1'b1;
         MODE_NORM: begin
            len_eff  = ONE_FIX;
            scale_in = sq_chain[ROOT_W].root != ONE_FIX;
         end
         default:    scale_in = 1'b0;
      endcase
      dec_in.valid = sq_chain[ROOT_W].valid;
      dec_in.scale = scale_in && sq_chain[ROOT_W].nonzero;
      dec_in.comp  = sq_chain[ROOT_W].comp;
      dec_in.div   = sq_chain[ROOT_W].root;
      for (int i = 0; i < LANES; i++) begin
         mag_d[i] = sq_chain[ROOT_W].comp[i][COMP_W-1] ?
                    (~sq_chain[ROOT_W].comp[i] + 1'b1) : sq_chain[ROOT_W].comp[i];
         dec_in.num[i] = mag_d[i] * len_eff;
         dec_in.rem[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff <= dec_in;
      if (reset) begin
         dec_ff.valid <= 1'b0;
      end
   end

   assign dv_chain[0] = dec_ff;

   // Divide chain
   for (genvar k = 0; k < NUM_W; k++) begin : g_div
      vms_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (dv_chain[k]),
         .stage_out (dv_chain[k+1])
      );
   end

   // Output stage: restore sign and saturate, or pass an unscaled vector through
   always_comb begin
      quot = '0;
      for (int i = 0; i < LANES; i++) begin
         quot = dv_chain[NUM_W].num[i];
         res_sat[i] = 1'b0;
         if (dv_chain[NUM_W].comp[i][COMP_W-1]) begin
            if (quot > NUM_W'(ONE_FIX) << (COMP_W - 1 - FRAC_BITS)) begin
               res_sat[i]  = 1'b1;
               res_comp[i] = {1'b1, {(COMP_W-1){1'b0}}};
            end else begin
               res_comp[i] = COMP_W'(~quot + 1'b1);
            end
         end else begin
            if (quot > (NUM_W'(1) << (COMP_W - 1)) - 1'b1) begin
               res_sat[i]  = 1'b1;
               res_comp[i] = {1'b0, {(COMP_W-1){1'b1}}};
            end else begin
               res_comp[i] = quot[COMP_W-1:0];
            end
         end
      end
      if (dv_chain[NUM_W].scale) begin
         rsp_in.out_x      = res_comp[0];
         rsp_in.out_y      = res_comp[1];
         rsp_in.out_z      = res_comp[2];
         rsp_in.was_scaled = 1'b1;
         rsp_in.saturated  = |res_sat;
      end else begin
         rsp_in.out_x      = dv_chain[NUM_W].comp[0];
         rsp_in.out_y      = dv_chain[NUM_W].comp[1];
         rsp_in.out_z      = dv_chain[NUM_W].comp[2];
         rsp_in.was_scaled = 1'b0;
         rsp_in.saturated  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_chain[NUM_W].valid;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp        = rsp_ff;

`ifndef NO_ASSERTIONS
   // Every accepted transaction yields a result a fixed time later
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("result missing at fixed latency");

   // A result appears only for an accepted transaction
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without transaction");

   // An unchanged vector never reports saturation
   a_pass_nosat: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp.was_scaled) |-> !rsp.saturated)
      else $error("saturation on passed vector");

   // A zero vector leaves the root chain with a zero root
   a_zero_root: assert property (@(posedge clock) disable iff (reset)
      (sq_chain[ROOT_W].valid && !sq_chain[ROOT_W].nonzero) |-> (sq_chain[ROOT_W].root == '0))
      else $error("nonzero root for zero vector");
`endif

endmodule
